// ===== hw/rtl/wsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants for the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_EXT  = 6'b000100,
    PH_KEY  = 6'b001000,
    PH_PAY  = 6'b010000,
    PH_TAIL = 6'b100000
  } phase_t;

  // Frame status codes
  localparam logic [1:0] ST_FINAL = 2'd0;
  localparam logic [1:0] ST_MORE  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // Header constants
  localparam logic [7:0] FLAG_MASK = 8'h80;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    logic [1:0] frame_status;
  } result_t;

endpackage

// ===== hw/rtl/wsfp_parser.sv =====
// ----------------------------------------------------------------------------
// wsfp_parser
// Frame state and per-byte next-state logic; produces at most one result
// for each byte stepped through.
// ----------------------------------------------------------------------------
module wsfp_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              res_valid,
  output wsfp_pkg::result_t res
);
  import wsfp_pkg::*;

  phase_t                   phase, phase_next;
  logic                     fin, fin_next;
  logic                     mask, mask_next;
  logic [3:0]               left, left_next;
  logic [LENGTH_BITS-1:0]   remain, remain_next;
  logic                     ovf, ovf_next;
  logic [31:0]              key, key_next;
  logic [1:0]               pos, pos_next;

  logic                     start_body;
  logic                     body_zero;
  logic [6:0]               len7;
  logic [LENGTH_BITS-1:0]   shifted;
  logic                     ovf_acc;
  logic [7:0]               key_byte;
  logic                     pay_valid;
  logic [7:0]               pay_byte;

  assign len7     = in_byte[6:0];
  assign shifted  = {remain[LENGTH_BITS-9:0], in_byte};
  assign ovf_acc  = ovf | (remain[LENGTH_BITS-1 -: 8] != 8'd0);
  assign key_byte = key[8*(3-pos) +: 8];

  always_comb begin
    phase_next  = phase;
    fin_next    = fin;
    mask_next   = mask;
    left_next   = left;
    remain_next = remain;
    ovf_next    = ovf;
    key_next    = key;
    pos_next    = pos;
    start_body  = 1'b0;
    body_zero   = 1'b0;
    pay_valid   = 1'b0;
    pay_byte    = 8'd0;

    case (phase)
      PH_HDR0: begin
        fin_next   = in_byte[7];
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        mask_next   = (in_byte & FLAG_MASK) != 8'd0;
        ovf_next    = 1'b0;
        remain_next = '0;
        if (len7 == LEN_EXT16) begin
          left_next  = EXT16_BYTES;
          phase_next = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          left_next  = EXT64_BYTES;
          phase_next = PH_EXT;
        end else begin
          remain_next = LENGTH_BITS'(len7);
          start_body  = 1'b1;
          body_zero   = (len7 == 7'd0);
        end
      end
      PH_EXT: begin
        left_next = left - 4'd1;
        if (left == 4'd1) begin
          // saturate lengths that do not fit
          remain_next = ovf_acc ? '1 : shifted;
          start_body  = 1'b1;
          body_zero   = !ovf_acc && (shifted == '0);
        end else begin
          remain_next = shifted;
          ovf_next    = ovf_acc;
        end
      end
      PH_KEY: begin
        key_next  = {key[23:0], in_byte};
        left_next = left - 4'd1;
        if (left == 4'd1) begin
          pos_next   = 2'd0;
          phase_next = (remain == '0) ? PH_TAIL : PH_PAY;
        end
      end
      PH_PAY: begin
        pay_valid   = 1'b1;
        pay_byte    = mask ? (in_byte ^ key_byte) : in_byte;
        pos_next    = pos + 2'd1;
        remain_next = remain - LENGTH_BITS'(1);
        if (remain == LENGTH_BITS'(1)) begin
          phase_next = PH_TAIL;
        end
      end
      PH_TAIL: begin
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    if (start_body) begin
      if (mask_next) begin
        left_next  = KEY_BYTES;
        key_next   = 32'd0;
        phase_next = PH_KEY;
      end else begin
        pos_next   = 2'd0;
        phase_next = body_zero ? PH_TAIL : PH_PAY;
      end
    end

    res.payload_byte  = pay_byte;
    res.payload_valid = pay_valid;
    res.frame_done    = in_last;
    res.frame_status  = 2'd0;
    if (in_last) begin
      res.frame_status = (phase_next == PH_TAIL) ? (fin ? ST_FINAL : ST_MORE) : ST_TRUNC;
      // each buffer starts clean
      phase_next  = PH_HDR0;
      fin_next    = 1'b0;
      mask_next   = 1'b0;
      left_next   = 4'd0;
      remain_next = '0;
      ovf_next    = 1'b0;
      key_next    = 32'd0;
      pos_next    = 2'd0;
    end
    res_valid = pay_valid | in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR0;
      fin    <= 1'b0;
      mask   <= 1'b0;
      left   <= 4'd0;
      remain <= '0;
      ovf    <= 1'b0;
      key    <= 32'd0;
      pos    <= 2'd0;
    end else if (step) begin
      phase  <= phase_next;
      fin    <= fin_next;
      mask   <= mask_next;
      left   <= left_next;
      remain <= remain_next;
      ovf    <= ovf_next;
      key    <= key_next;
      pos    <= pos_next;
    end
  end

endmodule

// ===== hw/rtl/wsfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// wsfp_out_stage
// Result register facing the output stream; holds a result until taken.
// ----------------------------------------------------------------------------
module wsfp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wsfp_pkg::result_t res_in,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic              can_load,
  output wsfp_pkg::result_t res_out
);
  import wsfp_pkg::*;

  logic    held;
  result_t res_q;

  assign can_load   = !held || out_tready;
  assign out_tvalid = held;
  assign res_out    = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (can_load) begin
      held <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_q <= res_in;
    end
  end

endmodule

// ===== hw/rtl/websocket_frame_parser.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_parser
// WebSocket (RFC 6455) frame deframer: header decode, unmasking, status.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and keeps that rate with no gaps while
// the output is not stalled. Each accepted byte is held in the input
// register, then the frame state and its result are updated in one step
// into the result register. Payload bytes leave unmasked as they arrive;
// the buffer's last byte always gives a result with tlast set and the
// status (final, non-final, truncated) in tuser. On a truncated status the
// payload already sent for that buffer is to be dropped. Bytes past the
// payload and header-only bytes give no result. Backpressure on the output
// stalls the input side in the same cycle once the input register is full.
module websocket_frame_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // end_of_buffer
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] payload_byte
  output logic [2:0] m_axis_tuser,  // [0] payload_valid, [2:1] frame_status
  output logic       m_axis_tlast   // frame_done
);
  import wsfp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_ready;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    res_q;

  assign s_axis_tready = !in_valid || out_ready;
  assign step          = in_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  wsfp_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step && res_valid),
    .res_in     (res),
    .out_tready (m_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .can_load   (out_ready),
    .res_out    (res_q)
  );

  assign m_axis_tdata = res_q.payload_byte;
  assign m_axis_tuser = {res_q.frame_status, res_q.payload_valid};
  assign m_axis_tlast = res_q.frame_done;

  // every result carries a byte, a status, or both
  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast))
    else $error("result with neither payload nor end of buffer");

  // status only on the last result of a buffer
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == ST_FINAL))
    else $error("frame status set before end of buffer");

  // status-only result carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
    else $error("nonzero byte on a status-only result");

  // a stalled output blocks the input once the input register is full
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && in_valid) |-> !s_axis_tready)
    else $error("input accepted while pipeline is stalled and full");

endmodule

// ===== dv/websocket_frame_parser_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_checker
// Watches both stream ports of the frame parser. Every accepted input byte is
// run through a local deframer that predicts its result, if it has one. Every
// accepted output request is then compared, field by field, against the
// oldest prediction.
// ----------------------------------------------------------------------------
module websocket_frame_parser_checker #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_buffer
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  input  logic [2:0] m_axis_tuser,   // [0] payload_valid, [2:1] frame_status
  input  logic       m_axis_tlast,   // frame_done
  output int         errors,
  output int         pending
);
  import wsfp_pkg::*;

  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

  // deframer state
  phase_t      phase;
  logic        fin_seen;
  logic        masked;
  logic [3:0]  hdr_left;
  logic [63:0] remaining;
  logic [31:0] key;
  logic [1:0]  key_pos;

  result_t     expected_q[$];
  int          fail_count = 0;
  int          queued = 0;

  assign errors  = fail_count;
  assign pending = queued;

  task automatic clear_state();
    phase     = PH_HDR0;
    fin_seen  = 1'b0;
    masked    = 1'b0;
    hdr_left  = '0;
    remaining = '0;
    key       = '0;
    key_pos   = '0;
  endtask

  task automatic open_payload();
    key_pos = '0;
    phase   = (remaining == '0) ? PH_TAIL : PH_PAY;
  endtask

  task automatic open_body();
    if (masked) begin
      hdr_left = KEY_BYTES;
      key      = '0;
      phase    = PH_KEY;
    end else begin
      open_payload();
    end
  endtask

  // One received byte; queues a result for payload bytes and the last byte.
  task automatic deframe_byte(input logic [7:0] b, input logic last_flag);
    result_t    r;
    logic [6:0] len7;
    r    = '0;
    len7 = b[6:0];
    case (phase)
      PH_HDR0: begin
        fin_seen = b[7];
        phase    = PH_HDR1;
      end
      PH_HDR1: begin
        masked    = (b & FLAG_MASK) != '0;
        remaining = '0;
        if (len7 == LEN_EXT16) begin
          hdr_left = EXT16_BYTES;
          phase    = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          hdr_left = EXT64_BYTES;
          phase    = PH_EXT;
        end else begin
          remaining = 64'(len7);
          open_body();
        end
      end
      PH_EXT: begin
        // big-endian extended length, top bit not checked
        remaining = {remaining[55:0], b};
        hdr_left  = hdr_left - 4'd1;
        if (hdr_left == '0) begin
          if (remaining > LEN_MAX) remaining = LEN_MAX;
          open_body();
        end
      end
      PH_KEY: begin
        key      = {key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == '0) open_payload();
      end
      PH_PAY: begin
        r.payload_byte  = masked ? (b ^ key[31 - 8*key_pos -: 8]) : b;
        r.payload_valid = 1'b1;
        key_pos         = key_pos + 2'd1;
        remaining       = remaining - 64'd1;
        if (remaining == '0) phase = PH_TAIL;
      end
      default: ;  // trailing bytes are dropped
    endcase
    if (r.payload_valid || last_flag) begin
      r.frame_done = last_flag;
      if (last_flag) begin
        if (phase == PH_TAIL) r.frame_status = fin_seen ? ST_FINAL : ST_MORE;
        else r.frame_status = ST_TRUNC;
        clear_state();
      end
      expected_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_state();
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected output request: tdata %0h tuser %0h tlast %0b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("payload_byte", want.payload_byte, m_axis_tdata);
          check_field("payload_valid", 8'(want.payload_valid), 8'(m_axis_tuser[0]));
          check_field("frame_done", 8'(want.frame_done), 8'(m_axis_tlast));
          check_field("frame_status", 8'(want.frame_status), 8'(m_axis_tuser[2:1]));
        end
      end
    end
    queued <= expected_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the WebSocket frame parser: a few hand-built buffers for the
// header corner cases, then random frames (masked or not, short, 16-bit and
// 64-bit lengths, truncated, with trailing bytes) plus some raw noise. The
// sender runs in bursts, the receiver stalls on its own pattern, and the
// checker module does all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LEN_BITS  = 64;
  localparam int NUM_BYTES = 1650;

  typedef logic [7:0] byte_q_t[$];

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  int mismatches;
  int outstanding;
  int burst_left = 0;
  int sent = 0;

  websocket_frame_parser #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  websocket_frame_parser_checker #(.LENGTH_BITS(LEN_BITS)) chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (mismatches),
    .pending       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: always ready, coin flip, mostly stalled, fixed on/off cycle
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      case ((rx_cycle / 250) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((rx_cycle % 8) < 3);
      endcase
      rx_cycle++;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last_flag);
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 48));
      repeat ($urandom_range(0, 5)) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last_flag;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_buffer(input byte_q_t frame_q);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    byte_q_t     frame_q;
    logic [63:0] len;
    logic        mask_bit;
    int          kind;
    int          len_sel;
    int          n_pay;
    int          n_buffers;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    n_buffers     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one-byte buffer: header cut short
    send_buffer('{8'hFF});
    // non-final, empty payload
    send_buffer('{8'h00, 8'h00});
    // 16-bit length of one, then a trailing byte
    send_buffer('{8'h80, 8'h7E, 8'h00, 8'h01, 8'hAA, 8'h55});
    // 64-bit length all ones, masked, buffer ends before the key
    send_buffer('{8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // masked, one payload byte
    send_buffer('{8'h81, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A});
    wait_drained();

    while (sent < NUM_BYTES) begin
      kind    = int'($urandom_range(0, 9));
      frame_q = {};
      if (kind == 0) begin
        repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      end else begin
        frame_q.push_back(8'($urandom));
        mask_bit = 1'($urandom_range(0, 1));
        len_sel  = int'($urandom_range(0, 5));
        case (len_sel)
          0, 1, 2: begin
            len = 64'($urandom_range(0, 15));
            frame_q.push_back({mask_bit, len[6:0]});
          end
          3: begin
            len = 64'($urandom_range(0, 125));
            frame_q.push_back({mask_bit, len[6:0]});
          end
          4: begin
            len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
                                               : 64'($urandom_range(0, 40));
            frame_q.push_back({mask_bit, 7'd126});
            frame_q.push_back(len[15:8]);
            frame_q.push_back(len[7:0]);
          end
          default: begin
            len = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                               : 64'($urandom_range(0, 40));
            frame_q.push_back({mask_bit, 7'd127});
            for (int i = 7; i >= 0; i--) frame_q.push_back(len[8*i +: 8]);
          end
        endcase
        if (mask_bit) repeat (4) frame_q.push_back(8'($urandom));
        // huge lengths can't be sent whole; those buffers end mid payload
        n_pay = (len > 150) ? int'($urandom_range(0, 40)) : int'(len);
        repeat (n_pay) frame_q.push_back(8'($urandom));
        if (n_pay == len) repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
        if (kind == 1 && frame_q.size() > 1)
          frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
      end
      send_buffer(frame_q);
      n_buffers++;
      if (n_buffers == 40) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("websocket_frame_parser: match");
    end else begin
      $display("websocket_frame_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("websocket_frame_parser: mismatch");
    $finish;
  end

endmodule

// ===== websocket_frame_parser.f =====
hw/rtl/wsfp_pkg.sv
hw/rtl/wsfp_parser.sv
hw/rtl/wsfp_out_stage.sv
hw/rtl/websocket_frame_parser.sv
dv/websocket_frame_parser_checker.sv
dv/testbench.sv
